// ===== sv/snps_pkg.sv =====
// Shared types and constants of the spoken-number player sequencer.
package snps_pkg;

  // Item kinds on the input channel; the fourth code is ignored.
  typedef enum logic [1:0] {
    OP_ANNOUNCE = 2'b00,
    OP_RX       = 2'b01,
    OP_POLL     = 2'b10
  } op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_FOLDER = 2'd0,
    CFG_EMPTY  = 2'd1,
    CFG_PLAY   = 2'd2,
    CFG_FINISH = 2'd3
  } cfg_idx_t;

  localparam logic [7:0] FOLDER_RESET = 8'd1;
  localparam logic [7:0] EMPTY_RESET  = 8'd0;
  localparam logic [7:0] PLAY_RESET   = 8'd15;
  localparam logic [7:0] FINISH_RESET = 8'd61;

  localparam logic [7:0] FRAME_START   = 8'h7E;
  localparam logic [7:0] FRAME_VERSION = 8'hFF;
  localparam logic [7:0] FRAME_LENGTH  = 8'h06;
  localparam logic [7:0] FRAME_END     = 8'hEF;
  localparam logic [3:0] FRAME_LAST    = 4'd9;

  localparam logic [7:0] CLIP_MINUS = 8'd250;
  localparam logic [7:0] CLIP_ZERO  = 8'd200;

  // Byte position in a received message that carries the command.
  localparam int RX_KEEP_POS = 3;

  localparam int MAG_W = 14;
  localparam logic [MAG_W-1:0] MAX_MAGNITUDE = 14'd9999;

  // Prefix, sign, four digit places and suffix.
  localparam int MAX_CLIPS  = 7;
  localparam int CLIP_CNT_W = $clog2(MAX_CLIPS + 1);

  localparam int CMD_FIFO_DEPTH = 4;
  localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
  localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] folder_number;
    logic [7:0] empty_code;
    logic [7:0] play_command;
    logic [7:0] finish_code;
  } cfg_t;

  // A classified word handed from the front end to the back end.
  typedef struct packed {
    logic [1:0]                      op;
    logic [7:0]                      rx_byte;
    logic [CLIP_CNT_W-1:0]           n_clips;
    logic [MAX_CLIPS-1:0][7:0]       clips;
  } cmd_t;

endpackage

// ===== sv/snps_front.sv =====
// Front end: accepts input words, splits announce numbers into clips, packs commands.
module snps_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           operation,
  input  logic [7:0]           prefix_clip,
  input  logic signed [14:0]   number,
  input  logic [7:0]           suffix_clip,
  input  logic [7:0]           rx_byte,
  input  logic [7:0]           empty_code,
  input  logic                 fifo_full,
  output logic                 push,
  output snps_pkg::cmd_t       push_cmd
);

  localparam int FE_STAGES = 4;

  localparam logic [2:0] SLOT_PREFIX    = 3'd0;
  localparam logic [2:0] SLOT_SIGN      = 3'd1;
  localparam logic [2:0] SLOT_THOUSANDS = 3'd2;
  localparam logic [2:0] SLOT_HUNDREDS  = 3'd3;
  localparam logic [2:0] SLOT_TENS      = 3'd4;
  localparam logic [2:0] SLOT_ONES      = 3'd5;
  localparam logic [2:0] SLOT_SUFFIX    = 3'd6;

  localparam logic [snps_pkg::MAG_W-1:0] PLACE_THOUSANDS = 14'd1000;
  localparam logic [snps_pkg::MAG_W-1:0] PLACE_HUNDREDS  = 14'd100;
  localparam logic [snps_pkg::MAG_W-1:0] PLACE_TENS      = 14'd10;
  localparam logic [snps_pkg::MAG_W-1:0] PLACE_ONES      = 14'd1;
  localparam logic [7:0] BASE_THOUSANDS = 8'd40;
  localparam logic [7:0] BASE_HUNDREDS  = 8'd30;
  localparam logic [7:0] BASE_TENS      = 8'd20;
  localparam logic [7:0] BASE_ONES      = 8'd10;
  localparam logic [snps_pkg::MAG_W-1:0] TEEN_LIMIT = 14'd19;

  typedef struct packed {
    logic [1:0]                          op;
    logic [7:0]                          rx_byte;
    logic [snps_pkg::MAG_W-1:0]          r;
    logic [snps_pkg::MAX_CLIPS-1:0][7:0] slot;
    logic [snps_pkg::MAX_CLIPS-1:0]      slot_v;
  } fe_item_t;

  // One digit place: nine parallel compares against the place multiples pick
  // the digit. Once the rest is 1..19 it goes out whole as a single clip.
  function automatic fe_item_t place_apply(input fe_item_t it,
                                           input logic [snps_pkg::MAG_W-1:0] place,
                                           input logic [7:0] base,
                                           input logic [2:0] slot);
    fe_item_t                   o;
    logic [3:0]                 d;
    logic [snps_pkg::MAG_W-1:0] sub;
    o = it;
    d = '0;
    sub = '0;
    o.slot_v[slot] = 1'b0;
    o.slot[slot] = '0;
    for (int k = 1; k < 10; k++) begin
      if (it.r >= snps_pkg::MAG_W'(k) * place) begin
        d = 4'(k);
        sub = snps_pkg::MAG_W'(k) * place;
      end
    end
    if (it.r > TEEN_LIMIT) begin
      o.r = it.r - sub;
      o.slot[slot] = base + 8'(d);
      o.slot_v[slot] = (d != 4'd0);
    end else if (it.r != '0) begin
      o.r = '0;
      o.slot[slot] = it.r[7:0];
      o.slot_v[slot] = 1'b1;
    end
    return o;
  endfunction

  logic                  advance;
  logic [FE_STAGES-1:0]  st_v;
  fe_item_t              st [FE_STAGES];
  fe_item_t              stage_in;
  fe_item_t              after_th;
  fe_item_t              after_hu;
  fe_item_t              after_te;
  fe_item_t              last_item;
  logic [14:0]           num_bits;
  logic [14:0]           abs_val;
  logic [snps_pkg::MAG_W-1:0] mag;
  logic                  neg;
  logic [snps_pkg::CLIP_CNT_W-1:0] cnt;
  logic [snps_pkg::MAX_CLIPS-1:0][7:0] packed_clips;
  logic                  is_cmd;

  // The whole pipeline moves as one; it freezes only when the last stage
  // holds a word that the command queue cannot take.
  assign advance  = !(st_v[FE_STAGES-1] && fifo_full);
  assign in_stall = !advance;

  always_comb begin
    num_bits = number;
    neg = num_bits[14];
    abs_val = neg ? (~num_bits + 15'd1) : num_bits;
    mag = (abs_val > {1'b0, snps_pkg::MAX_MAGNITUDE}) ? snps_pkg::MAX_MAGNITUDE
                                                       : abs_val[13:0];
    stage_in = '0;
    stage_in.op = operation;
    stage_in.rx_byte = rx_byte;
    stage_in.r = mag;
    stage_in.slot[SLOT_PREFIX] = prefix_clip;
    stage_in.slot_v[SLOT_PREFIX] = (prefix_clip != empty_code);
    if (neg) begin
      stage_in.slot[SLOT_SIGN] = snps_pkg::CLIP_MINUS;
      stage_in.slot_v[SLOT_SIGN] = 1'b1;
    end else if (mag == '0) begin
      stage_in.slot[SLOT_SIGN] = snps_pkg::CLIP_ZERO;
      stage_in.slot_v[SLOT_SIGN] = 1'b1;
    end
    stage_in.slot[SLOT_SUFFIX] = suffix_clip;
    stage_in.slot_v[SLOT_SUFFIX] = (suffix_clip != empty_code);
  end

  always_comb begin
    after_th  = place_apply(st[0], PLACE_THOUSANDS, BASE_THOUSANDS, SLOT_THOUSANDS);
    after_hu  = place_apply(st[1], PLACE_HUNDREDS, BASE_HUNDREDS, SLOT_HUNDREDS);
    after_te  = place_apply(st[2], PLACE_TENS, BASE_TENS, SLOT_TENS);
    last_item = place_apply(st[3], PLACE_ONES, BASE_ONES, SLOT_ONES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_v <= '0;
    end else if (advance) begin
      st_v <= {st_v[FE_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st[0] <= stage_in;
      st[1] <= after_th;
      st[2] <= after_hu;
      st[3] <= after_te;
    end
  end

  // Squeeze the used slots to the front of the clip list, in slot order.
  always_comb begin
    cnt = '0;
    packed_clips = '0;
    for (int s = 0; s < snps_pkg::MAX_CLIPS; s++) begin
      if (last_item.slot_v[s]) begin
        packed_clips[cnt] = last_item.slot[s];
        cnt = cnt + 1'b1;
      end
    end
  end

  assign is_cmd = (last_item.op == snps_pkg::OP_ANNOUNCE) ||
                  (last_item.op == snps_pkg::OP_RX) ||
                  (last_item.op == snps_pkg::OP_POLL);

  assign push = st_v[FE_STAGES-1] && !fifo_full && is_cmd;

  always_comb begin
    push_cmd.op      = last_item.op;
    push_cmd.rx_byte = last_item.rx_byte;
    push_cmd.n_clips = cnt;
    push_cmd.clips   = packed_clips;
  end

endmodule

// ===== sv/snps_fifo.sv =====
// Short command queue between the front end and the back end.
module snps_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  snps_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output snps_pkg::cmd_t pop_cmd
);

  snps_pkg::cmd_t                     mem [snps_pkg::CMD_FIFO_DEPTH];
  logic [snps_pkg::CMD_PTR_W-1:0]     wr_ptr;
  logic [snps_pkg::CMD_PTR_W-1:0]     rd_ptr;
  logic [snps_pkg::CMD_CNT_W-1:0]     count;

  assign full    = (count == snps_pkg::CMD_CNT_W'(snps_pkg::CMD_FIFO_DEPTH));
  assign avail   = (count != '0);
  assign pop_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("command queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !avail))
    else $error("command queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
      count <= snps_pkg::CMD_CNT_W'(snps_pkg::CMD_FIFO_DEPTH))
    else $error("command queue count beyond depth");
`endif

endmodule

// ===== sv/snps_back.sv =====
// Back end: clip queue, receiver state, ready flag and the serial frame sender.
module snps_back #(
  parameter int QUEUE_DEPTH    = 10,
  parameter int RX_BUFFER_SIZE = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  snps_pkg::cfg_t cfg,
  input  logic           cmd_avail,
  input  snps_pkg::cmd_t cmd,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     tx_byte,
  output logic           frame_last
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int RXC_W = $clog2(RX_BUFFER_SIZE + 1);

  logic [7:0]       clip_q [QUEUE_DEPTH];
  logic [7:0]       fill   [QUEUE_DEPTH];
  logic [CNT_W-1:0] rd_idx;
  logic             ready_flag;
  logic [RXC_W-1:0] rx_count;
  logic [RXC_W-1:0] rx_count_inc;
  logic [7:0]       rx_third;
  logic [7:0]       rx_third_new;

  logic             frm_active;
  logic [3:0]       frm_pos;
  logic [7:0]       frm_clip;
  logic [15:0]      frm_chk;
  logic [15:0]      sum16;
  logic [7:0]       cur_clip;
  logic [7:0]       frame_byte;

  logic             load_out;
  logic             last_load;
  logic             poll_hit;
  logic             fire;

  assign cur_clip  = clip_q[rd_idx[IDX_W-1:0]];
  assign poll_hit  = ready_flag && (rd_idx < CNT_W'(QUEUE_DEPTH)) &&
                     (cur_clip != cfg.empty_code);

  // The output register takes a new frame byte whenever it is empty or drained.
  assign load_out  = frm_active && (!out_valid || !out_stall);
  assign last_load = load_out && (frm_pos == snps_pkg::FRAME_LAST);
  assign pop       = cmd_avail && (!frm_active || last_load);
  assign fire      = pop && (cmd.op == snps_pkg::OP_POLL) && poll_hit;

  assign sum16 = 16'(snps_pkg::FRAME_VERSION) + 16'(snps_pkg::FRAME_LENGTH) +
                 16'(cfg.play_command) + 16'(cfg.folder_number) + 16'(cur_clip);

  assign rx_count_inc = rx_count + 1'b1;
  assign rx_third_new = (rx_count == RXC_W'(snps_pkg::RX_KEEP_POS)) ? cmd.rx_byte
                                                                     : rx_third;

  // An announce rewrites the whole queue: packed clips first, empty after.
  always_comb begin
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      fill[j] = cfg.empty_code;
    end
    for (int k = 0; k < snps_pkg::MAX_CLIPS; k++) begin
      if (snps_pkg::CLIP_CNT_W'(k) < cmd.n_clips) begin
        fill[k] = cmd.clips[k];
      end
    end
  end

  always_comb begin
    case (frm_pos)
      4'd0:    frame_byte = snps_pkg::FRAME_START;
      4'd1:    frame_byte = snps_pkg::FRAME_VERSION;
      4'd2:    frame_byte = snps_pkg::FRAME_LENGTH;
      4'd3:    frame_byte = cfg.play_command;
      4'd4:    frame_byte = 8'd0;
      4'd5:    frame_byte = cfg.folder_number;
      4'd6:    frame_byte = frm_clip;
      4'd7:    frame_byte = frm_chk[15:8];
      4'd8:    frame_byte = frm_chk[7:0];
      default: frame_byte = snps_pkg::FRAME_END;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
        clip_q[j] <= snps_pkg::EMPTY_RESET;
      end
      rd_idx     <= '0;
      ready_flag <= 1'b0;
      rx_count   <= '0;
      rx_third   <= '0;
      frm_active <= 1'b0;
      frm_pos    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        unique case (cmd.op)
          snps_pkg::OP_ANNOUNCE: begin
            clip_q     <= fill;
            rd_idx     <= '0;
            ready_flag <= 1'b1;
          end
          snps_pkg::OP_RX: begin
            if (cmd.rx_byte == snps_pkg::FRAME_END) begin
              if (rx_third_new == cfg.finish_code) begin
                ready_flag <= 1'b1;
              end
              rx_count <= '0;
              rx_third <= '0;
            end else if (rx_count_inc >= RXC_W'(RX_BUFFER_SIZE)) begin
              rx_count <= '0;
              rx_third <= '0;
            end else begin
              rx_count <= rx_count_inc;
              rx_third <= rx_third_new;
            end
          end
          snps_pkg::OP_POLL: begin
            if (poll_hit) begin
              rd_idx     <= rd_idx + 1'b1;
              rx_count   <= '0;
              rx_third   <= '0;
              ready_flag <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end

      // A new frame may start in the cycle the previous one hands over its end byte.
      if (fire) begin
        frm_active <= 1'b1;
        frm_pos    <= '0;
      end else if (last_load) begin
        frm_active <= 1'b0;
      end else if (load_out) begin
        frm_pos <= frm_pos + 1'b1;
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      frm_clip <= cur_clip;
      frm_chk  <= 16'd0 - sum16;
    end
    if (load_out) begin
      tx_byte    <= frame_byte;
      frame_last <= (frm_pos == snps_pkg::FRAME_LAST);
    end
  end

`ifndef SYNTHESIS
  a_last_is_end: assert property (@(posedge clk) disable iff (rst)
      (out_valid && frame_last) |-> (tx_byte == snps_pkg::FRAME_END))
    else $error("frame closed on a byte other than the end byte");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
      rd_idx <= CNT_W'(QUEUE_DEPTH))
    else $error("clip queue read index beyond depth");
  a_rx_bound: assert property (@(posedge clk) disable iff (rst)
      rx_count < RXC_W'(RX_BUFFER_SIZE))
    else $error("receive count reached buffer size");
  a_fire_starts: assert property (@(posedge clk) disable iff (rst)
      fire |=> (frm_active && (frm_pos == 4'd0)))
    else $error("accepted poll did not start a frame");
`endif

endmodule

// ===== sv/spoken_number_player_sequencer_top.sv =====
// Top level of the spoken-number player sequencer: configuration registers and wiring.
//
//   channel   handshake              payload
//   in        in_valid / in_stall    operation, prefix_clip, number, suffix_clip, rx_byte
//   out       out_valid / out_stall  tx_byte, frame_last
//   config    cfg_we                 cfg_index, cfg_data
//
// Announce and received-byte words are taken one per cycle while in_stall is low. A poll
// that plays a clip sends ten bytes, one per cycle through the output register while
// out_stall is low; the back end takes no other word until the last byte is loaded.
// Reset is synchronous and leaves every clip queue entry at zero. An output stall holds
// the frame and the back end; the four-word command queue then fills, the front pipeline
// freezes and in_stall rises.
module spoken_number_player_sequencer_top #(
  parameter int QUEUE_DEPTH    = 10,
  parameter int RX_BUFFER_SIZE = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          operation,
  input  logic [7:0]          prefix_clip,
  input  logic signed [14:0]  number,
  input  logic [7:0]          suffix_clip,
  input  logic [7:0]          rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          tx_byte,
  output logic                frame_last,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  snps_pkg::cfg_t cfg;
  snps_pkg::cmd_t push_cmd;
  snps_pkg::cmd_t pop_cmd;
  logic           push;
  logic           pop;
  logic           fifo_full;
  logic           cmd_avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.folder_number <= snps_pkg::FOLDER_RESET;
      cfg.empty_code    <= snps_pkg::EMPTY_RESET;
      cfg.play_command  <= snps_pkg::PLAY_RESET;
      cfg.finish_code   <= snps_pkg::FINISH_RESET;
    end else if (cfg_we) begin
      unique case (snps_pkg::cfg_idx_t'(cfg_index))
        snps_pkg::CFG_FOLDER: cfg.folder_number <= cfg_data;
        snps_pkg::CFG_EMPTY:  cfg.empty_code    <= cfg_data;
        snps_pkg::CFG_PLAY:   cfg.play_command  <= cfg_data;
        snps_pkg::CFG_FINISH: cfg.finish_code   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  snps_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .prefix_clip (prefix_clip),
    .number      (number),
    .suffix_clip (suffix_clip),
    .rx_byte     (rx_byte),
    .empty_code  (cfg.empty_code),
    .fifo_full   (fifo_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  snps_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .avail    (cmd_avail),
    .pop_cmd  (pop_cmd)
  );

  snps_back #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .RX_BUFFER_SIZE (RX_BUFFER_SIZE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd_avail  (cmd_avail),
    .cmd        (pop_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .tx_byte    (tx_byte),
    .frame_last (frame_last)
  );

endmodule
